/* design/lmtm_pkg.sv */
// Shared constants for the link memory transfer monitor.
// No dependencies; used by the core and its port checker.
package lmtm_pkg;

    // handshake characters
    localparam logic [7:0] CH_G_LO = 8'h67;  // 'g'
    localparam logic [7:0] CH_G_UP = 8'h47;  // 'G'
    localparam logic [7:0] CH_T_LO = 8'h74;  // 't'
    localparam logic [7:0] CH_T_UP = 8'h54;  // 'T'

    // command codes
    localparam logic [7:0] CMD_DUMP     = 8'h01;
    localparam logic [7:0] CMD_LOAD     = 8'h02;
    localparam logic [7:0] CMD_END      = 8'h64;
    localparam logic [7:0] CMD_END_ACK  = 8'h65;
    localparam logic [7:0] END_ACK_BYTE = 8'h02;

    // address remap
    localparam logic [31:0] REMAP_HIGH   = 32'hBE00_0000;
    localparam logic [31:0] WIN_BASE     = 32'h8078_0000;
    localparam logic [31:0] WIN_SPAN     = 32'h0008_0000;
    localparam logic [31:0] REMAP_TARGET = 32'h8000_0400;

endpackage

/* design/link_memory_transfer_monitor_core.sv */
// Top level of the link memory transfer monitor: protocol sequencer plus target memory.
// Depends on lmtm_pkg.
//
//  channel  | dir | tdata                 | tuser            | handshake
//  s_axis   | in  | [7:0] rx_byte         | -                | tvalid & tready
//  m_axis   | out | [7:0] tx_byte         | [0] session_end  | tvalid & tready
//
// Every input beat yields exactly one output beat, valid the cycle after it is taken:
// the sequencer step and the synchronous memory read both complete at the accepting
// edge and land in the output register. A new beat is taken every cycle while the
// output register is free or drains.
// Reset (i_rst_n low, synchronous) returns to the handshake; memory is not cleared.
// A stalled output holds its beat and the registered read data.
module link_memory_transfer_monitor_core #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
    output logic [0:0] m_axis_tuser    // [0] session_end
);

    localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;

    typedef enum logic [3:0] {
        PH_WAIT_G, PH_WAIT_T, PH_CMD, PH_ADDR, PH_LEN,
        PH_DUMP, PH_LOAD, PH_CSUM, PH_END2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_word, n_word;
    logic [1:0]  r_bidx, n_bidx;
    logic        r_load, n_load;
    logic [31:0] r_cur, n_cur;
    logic [30:0] r_rem, n_rem;
    logic [7:0]  r_sum, n_sum;
    logic        r_pend, n_pend;     // read data of last dump beat still to be summed

    logic        r_out_valid;
    logic        r_out_mem;          // output byte comes from memory read data
    logic [7:0]  r_out_tx;
    logic        r_out_end;
    logic [7:0]  r_rdata;

    logic [7:0]  mem [MEM_DEPTH];

    logic                     accept;
    logic                     mem_re, mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_raddr;
    logic [7:0]               tx_val;
    logic                     end_val, use_mem;
    logic [31:0]              word_next, addr_map;
    logic [30:0]              len_clip;
    logic [7:0]               sum_base;

    function automatic logic [31:0] remap(input logic [31:0] a);
        logic [31:0] t;
        t = (a >= lmtm_pkg::REMAP_HIGH) ? lmtm_pkg::REMAP_TARGET : a;
        if ((t - lmtm_pkg::WIN_BASE) <= lmtm_pkg::WIN_SPAN) t = lmtm_pkg::REMAP_TARGET;
        return t;
    endfunction

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign word_next = {r_word[23:0], s_axis_tdata};
    assign addr_map  = remap(r_cur);
    assign len_clip  = word_next[31] ? 31'd0 : word_next[30:0];
    assign sum_base  = r_pend ? r_sum + r_rdata : r_sum;

    // sequencer step for the beat being accepted
    always_comb begin
        n_phase   = r_phase;
        n_word    = r_word;
        n_bidx    = r_bidx;
        n_load    = r_load;
        n_cur     = r_cur;
        n_rem     = r_rem;
        n_sum     = sum_base;
        n_pend    = 1'b0;
        tx_val    = 8'd0;
        end_val   = 1'b0;
        use_mem   = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = r_cur[MEM_ADDR_BITS-1:0];
        case (r_phase)
            PH_WAIT_G: begin
                if (s_axis_tdata == lmtm_pkg::CH_G_UP) begin
                    n_phase = PH_WAIT_T;
                    tx_val  = lmtm_pkg::CH_T_LO;
                end else begin
                    tx_val  = lmtm_pkg::CH_G_LO;
                end
            end
            PH_WAIT_T: begin
                if (s_axis_tdata == lmtm_pkg::CH_T_UP) begin
                    n_phase = PH_CMD;
                end else begin
                    n_phase = PH_WAIT_G;
                    tx_val  = lmtm_pkg::CH_G_LO;
                end
            end
            PH_CMD: begin
                if (s_axis_tdata == lmtm_pkg::CMD_DUMP || s_axis_tdata == lmtm_pkg::CMD_LOAD) begin
                    n_load  = (s_axis_tdata == lmtm_pkg::CMD_LOAD);
                    n_sum   = 8'd0;
                    n_bidx  = 2'd0;
                    n_word  = 32'd0;
                    n_phase = PH_ADDR;
                end else if (s_axis_tdata == lmtm_pkg::CMD_END) begin
                    end_val = 1'b1;
                    n_phase = PH_WAIT_G;
                    tx_val  = lmtm_pkg::CH_G_LO;
                end else if (s_axis_tdata == lmtm_pkg::CMD_END_ACK) begin
                    n_phase = PH_END2;
                    tx_val  = lmtm_pkg::END_ACK_BYTE;
                end else begin
                    n_phase = PH_WAIT_G;
                    tx_val  = lmtm_pkg::CH_G_LO;
                end
            end
            PH_ADDR: begin
                n_word = word_next;
                n_bidx = r_bidx + 2'd1;
                if (r_bidx == 2'd3) begin
                    n_cur   = word_next;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_word = word_next;
                n_bidx = r_bidx + 2'd1;
                if (r_bidx == 2'd3) begin
                    if (r_cur == 32'd0) begin
                        // end of run: report checksum
                        n_phase = PH_CSUM;
                        tx_val  = sum_base;
                    end else begin
                        n_cur = addr_map;
                        n_rem = len_clip;
                        if (len_clip == 31'd0) begin
                            n_phase = PH_ADDR;
                        end else if (r_load) begin
                            n_phase = PH_LOAD;
                        end else begin
                            // first dump byte
                            n_phase   = PH_DUMP;
                            mem_re    = 1'b1;
                            use_mem   = 1'b1;
                            n_pend    = 1'b1;
                            mem_raddr = addr_map[MEM_ADDR_BITS-1:0];
                            n_cur     = addr_map + 32'd1;
                            n_rem     = len_clip - 31'd1;
                        end
                    end
                end
            end
            PH_DUMP: begin
                if (r_rem != 31'd0) begin
                    mem_re  = 1'b1;
                    use_mem = 1'b1;
                    n_pend  = 1'b1;
                    n_cur   = r_cur + 32'd1;
                    n_rem   = r_rem - 31'd1;
                end else begin
                    n_phase = PH_ADDR;
                end
            end
            PH_LOAD: begin
                mem_we = 1'b1;
                n_cur  = r_cur + 32'd1;
                n_rem  = r_rem - 31'd1;
                n_sum  = sum_base + s_axis_tdata;
                if (r_rem == 31'd1) n_phase = PH_ADDR;
            end
            PH_CSUM: begin
                n_phase = PH_WAIT_G;
                tx_val  = lmtm_pkg::CH_G_LO;
            end
            PH_END2: begin
                end_val = 1'b1;
                n_phase = PH_WAIT_G;
                tx_val  = lmtm_pkg::CH_G_LO;
            end
            default: begin
                n_phase = PH_WAIT_G;
                tx_val  = lmtm_pkg::CH_G_LO;
            end
        endcase
    end

    // target memory: at most one write or one registered read per accepted beat
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) mem[r_cur[MEM_ADDR_BITS-1:0]] <= s_axis_tdata;
        if (accept && mem_re) r_rdata <= mem[mem_raddr];
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT_G;
            r_word      <= 32'd0;
            r_bidx      <= 2'd0;
            r_load      <= 1'b0;
            r_cur       <= 32'd0;
            r_rem       <= 31'd0;
            r_sum       <= 8'd0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_word  <= n_word;
                r_bidx  <= n_bidx;
                r_load  <= n_load;
                r_cur   <= n_cur;
                r_rem   <= n_rem;
                r_sum   <= n_sum;
                r_pend  <= n_pend;
            end else begin
                // fold pending dump byte into the checksum
                r_sum  <= sum_base;
                r_pend <= 1'b0;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_tx  <= tx_val;
            r_out_end <= end_val;
            r_out_mem <= use_mem;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_mem ? r_rdata : r_out_tx;
    assign m_axis_tuser[0] = r_out_end;

endmodule

/* design/lmtm_checker.sv */
// Port-level checker for the link memory transfer monitor, bound to the core.
// Depends on lmtm_pkg and link_memory_transfer_monitor_core.
module lmtm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [0:0] m_axis_tuser
);

    // a session end always restarts the handshake
    a_end_sends_g: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == lmtm_pkg::CH_G_LO)
        else $error("session end beat without handshake byte");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed under stall");

    // every input beat gives an output beat next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("input beat produced no output beat");

    // no output beat appears without an input beat
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready) && (!m_axis_tvalid || m_axis_tready)
            |=> !m_axis_tvalid)
        else $error("output beat without input beat");

    // empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind link_memory_transfer_monitor_core lmtm_checker u_lmtm_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for link_memory_transfer_monitor_core: host byte streams are
// scored against an in-bench model of the link protocol. Depends on lmtm_pkg and the core.
module tb;

    localparam int         MEM_AW    = 16;
    localparam int         ITEM_GOAL = 2000;
    localparam int         STALL_MAX = 2000;
    localparam int         DRAIN_CYC = 16;
    localparam int         HOLD_AT   = 400;
    localparam int         HOLD_LEN  = 300;
    localparam logic [7:0] CMD_CODES = 8'h03;  // code-list command, not handled here

    typedef enum logic [3:0] {
        PH_WAIT_G, PH_WAIT_T, PH_CMD, PH_ADDR, PH_LEN, PH_DUMP, PH_LOAD, PH_CSUM, PH_END2
    } t_link_phase;

    // one exchange: host byte and the reply it should produce
    typedef struct packed {
        logic [7:0] rx;
        logic [7:0] tx;
        logic       sess_end;
    } t_xchg;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] tx_byte
    logic [0:0] m_axis_tuser;           // [0] session_end

    link_memory_transfer_monitor_core #(.MEM_ADDR_BITS(MEM_AW)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial forever #2 i_clk = ~i_clk;

    // protocol model state
    t_link_phase ph         = PH_WAIT_G;
    logic [31:0] shift_word = '0;
    logic [1:0]  byte_cnt   = '0;
    logic        load_sel   = 1'b0;
    logic [31:0] addr_ptr   = '0;
    logic [31:0] bytes_left = '0;
    logic [7:0]  xfer_sum   = '0;
    logic [7:0]  mem_img   [0:(1<<MEM_AW)-1];
    bit          mem_valid [0:(1<<MEM_AW)-1];

    // stimulus and scoreboard
    t_xchg       host_q[$];     // bytes still to send, with predicted replies
    t_xchg       reply_q[$];    // replies owed by the block for accepted beats
    logic [31:0] load_base[$];
    logic [31:0] load_len[$];
    t_xchg       cur_beat;
    int          total_items  = 0;
    int          in_count     = 0;
    int          out_count    = 0;
    int          errors       = 0;
    int          quiet_cycles = 0;
    int          src_gap      = 0;
    int          sink_gap     = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          idle_en      = 1'b0;
    logic        s_hs         = 1'b0;

    function automatic logic [31:0] remap_addr(input logic [31:0] a);
        logic [31:0] r;
        r = a;
        if (r >= lmtm_pkg::REMAP_HIGH)
            r = lmtm_pkg::REMAP_TARGET;
        if (r - lmtm_pkg::WIN_BASE <= lmtm_pkg::WIN_SPAN)
            r = lmtm_pkg::REMAP_TARGET;
        return r;
    endfunction

    // send one memory byte during a dump
    function logic [7:0] dump_byte();
        logic [7:0] b;
        b          = mem_img[addr_ptr[MEM_AW-1:0]];
        addr_ptr   = addr_ptr + 32'd1;
        bytes_left = bytes_left - 32'd1;
        xfer_sum   = xfer_sum + b;
        return b;
    endfunction

    // one completed exchange: advance the protocol and return the reply
    function t_xchg link_exchange(input logic [7:0] rx);
        t_xchg r;
        r.rx       = rx;
        r.tx       = 8'h00;
        r.sess_end = 1'b0;
        case (ph)
            PH_WAIT_T: begin
                if (rx == lmtm_pkg::CH_T_UP) begin
                    ph = PH_CMD;
                end else begin
                    ph   = PH_WAIT_G;
                    r.tx = lmtm_pkg::CH_G_LO;
                end
            end
            PH_CMD: begin
                if (rx == lmtm_pkg::CMD_DUMP || rx == lmtm_pkg::CMD_LOAD) begin
                    load_sel   = (rx == lmtm_pkg::CMD_LOAD);
                    xfer_sum   = '0;
                    byte_cnt   = '0;
                    shift_word = '0;
                    ph         = PH_ADDR;
                end else if (rx == lmtm_pkg::CMD_END) begin
                    r.sess_end = 1'b1;
                    ph         = PH_WAIT_G;
                    r.tx       = lmtm_pkg::CH_G_LO;
                end else if (rx == lmtm_pkg::CMD_END_ACK) begin
                    ph   = PH_END2;
                    r.tx = lmtm_pkg::END_ACK_BYTE;
                end else begin
                    ph   = PH_WAIT_G;
                    r.tx = lmtm_pkg::CH_G_LO;
                end
            end
            PH_ADDR: begin
                shift_word = {shift_word[23:0], rx};
                byte_cnt   = byte_cnt + 2'd1;
                if (byte_cnt == 2'd0) begin
                    addr_ptr = shift_word;
                    ph       = PH_LEN;
                end
            end
            PH_LEN: begin
                shift_word = {shift_word[23:0], rx};
                byte_cnt   = byte_cnt + 2'd1;
                if (byte_cnt == 2'd0) begin
                    if (addr_ptr == 32'd0) begin
                        // end of run: report the checksum
                        ph   = PH_CSUM;
                        r.tx = xfer_sum;
                    end else begin
                        addr_ptr   = remap_addr(addr_ptr);
                        bytes_left = shift_word[31] ? 32'd0 : shift_word;
                        if (bytes_left == 32'd0)
                            ph = PH_ADDR;
                        else if (load_sel)
                            ph = PH_LOAD;
                        else begin
                            ph   = PH_DUMP;
                            r.tx = dump_byte();
                        end
                    end
                end
            end
            PH_DUMP: begin
                if (bytes_left != 32'd0)
                    r.tx = dump_byte();
                else
                    ph = PH_ADDR;
            end
            PH_LOAD: begin
                mem_img[addr_ptr[MEM_AW-1:0]]   = rx;
                mem_valid[addr_ptr[MEM_AW-1:0]] = 1'b1;
                addr_ptr   = addr_ptr + 32'd1;
                bytes_left = bytes_left - 32'd1;
                xfer_sum   = xfer_sum + rx;
                if (bytes_left == 32'd0)
                    ph = PH_ADDR;
            end
            PH_CSUM: begin
                ph   = PH_WAIT_G;
                r.tx = lmtm_pkg::CH_G_LO;
            end
            PH_END2: begin
                r.sess_end = 1'b1;
                ph         = PH_WAIT_G;
                r.tx       = lmtm_pkg::CH_G_LO;
            end
            default: begin
                if (rx == lmtm_pkg::CH_G_UP) begin
                    ph   = PH_WAIT_T;
                    r.tx = lmtm_pkg::CH_T_LO;
                end else begin
                    r.tx = lmtm_pkg::CH_G_LO;
                end
            end
        endcase
        return r;
    endfunction

    // true when every byte the dump would read has been loaded before
    function automatic bit dump_safe(input logic [31:0] a, input logic [31:0] n);
        logic [31:0]       p;
        logic [MEM_AW-1:0] ix;
        if (n[31] || n == 32'd0)
            return 1'b1;
        p  = remap_addr(a);
        ix = p[MEM_AW-1:0];
        for (int i = 0; i < n; i++) begin
            if (!mem_valid[ix])
                return 1'b0;
            ix = ix + 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] byte_except(input logic [7:0] bad);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == bad)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] unknown_cmd();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = CMD_CODES;
            1: b = 8'h00;
            2: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
        endcase
        while (b == lmtm_pkg::CMD_DUMP || b == lmtm_pkg::CMD_LOAD ||
               b == lmtm_pkg::CMD_END || b == lmtm_pkg::CMD_END_ACK)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task put_byte(input logic [7:0] b);
        host_q.push_back(link_exchange(b));
    endtask

    task put_word(input logic [31:0] w);
        put_byte(w[31:24]);
        put_byte(w[23:16]);
        put_byte(w[15:8]);
        put_byte(w[7:0]);
    endtask

    // address and length, then the data bytes the record moves
    task put_record(input logic [31:0] a, input logic [31:0] n);
        put_word(a);
        put_word(n);
        while (ph == PH_DUMP || ph == PH_LOAD)
            put_byte(8'($urandom_range(0, 255)));
    endtask

    task pick_load(output logic [31:0] a, output logic [31:0] n);
        case ($urandom_range(0, 7))
            0: a = lmtm_pkg::REMAP_HIGH + $urandom_range(0, 3);
            1: a = lmtm_pkg::WIN_BASE + $urandom_range(0, lmtm_pkg::WIN_SPAN);
            2: begin
                case ($urandom_range(0, 4))
                    0: a = lmtm_pkg::WIN_BASE - 32'd1;
                    1: a = lmtm_pkg::WIN_BASE + lmtm_pkg::WIN_SPAN;
                    2: a = lmtm_pkg::WIN_BASE + lmtm_pkg::WIN_SPAN + 32'd1;
                    3: a = lmtm_pkg::REMAP_HIGH - 32'd1;
                    default: a = 32'hFFFF_FFFF;
                endcase
            end
            3: a = {8'($urandom_range(0, 255)), 8'h00, 16'hFFF0} + $urandom_range(0, 15);
            default: a = $urandom;
        endcase
        if (a == 32'd0)
            a = 32'd1;
        case ($urandom_range(0, 9))
            0: n = 32'd0;
            1: n = {1'b1, 31'($urandom)};
            default: n = $urandom_range(1, 24);
        endcase
        if (!n[31] && n != 32'd0) begin
            load_base.push_back(a);
            load_len.push_back(n);
            if (load_base.size() > 64) begin
                void'(load_base.pop_front());
                void'(load_len.pop_front());
            end
        end
    endtask

    // dumps re-read loaded ranges; anything else gets a zero or negative length
    task pick_dump(output logic [31:0] a, output logic [31:0] n);
        int          k;
        logic [31:0] off;
        case ($urandom_range(0, 9))
            0: begin
                a = $urandom;
                n = {1'b1, 31'($urandom)};
            end
            1: begin
                a = $urandom;
                n = 32'd0;
            end
            default: begin
                if (load_base.size() > 0) begin
                    k   = $urandom_range(0, load_base.size() - 1);
                    off = $urandom_range(0, load_len[k] - 1);
                    a   = load_base[k] + off;
                    n   = $urandom_range(1, load_len[k] - off);
                end else begin
                    a = $urandom;
                    n = 32'd0;
                end
            end
        endcase
        if (a == 32'd0) begin
            a = 32'd1;
            n = 32'd0;
        end
        if (!dump_safe(a, n))
            n = 32'd0;
    endtask

    // random session: line noise, handshake, then one command
    task gen_session();
        int          pick;
        bit          is_load;
        logic [31:0] a;
        logic [31:0] n;
        repeat ($urandom_range(0, 2))
            put_byte(byte_except(lmtm_pkg::CH_G_UP));
        if ($urandom_range(0, 5) == 0) begin
            put_byte(lmtm_pkg::CH_G_UP);
            put_byte(byte_except(lmtm_pkg::CH_T_UP));
        end
        put_byte(lmtm_pkg::CH_G_UP);
        put_byte(lmtm_pkg::CH_T_UP);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            put_byte(lmtm_pkg::CMD_END);
        end else if (pick == 1) begin
            put_byte(lmtm_pkg::CMD_END_ACK);
            put_byte(8'($urandom_range(0, 255)));
        end else if (pick == 2) begin
            put_byte(unknown_cmd());
        end else begin
            is_load = (pick < 12);
            put_byte(is_load ? lmtm_pkg::CMD_LOAD : lmtm_pkg::CMD_DUMP);
            repeat ($urandom_range(1, 4)) begin
                if (is_load)
                    pick_load(a, n);
                else
                    pick_dump(a, n);
                put_record(a, n);
            end
            // zero address closes the run; its length is still read
            put_record(32'd0, $urandom);
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // sender: offer queued bytes, idling in random bursts
    always @(negedge i_clk) begin
        idle_en = ((in_count / 200) % 4 != 3) && (total_items - in_count > 150);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_hs) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (host_q.size() > 0) begin
                cur_beat = host_q.pop_front();
                s_axis_tdata  <= cur_beat.rx;
                s_axis_tvalid <= 1'b1;
                if (idle_en && $urandom_range(0, 11) == 0)
                    src_gap = $urandom_range(1, 19);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && out_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 11) == 0)
                    sink_gap = $urandom_range(1, 19);
            end
        end
    end

    // monitor: log accepted input beats, score output beats
    always @(posedge i_clk) begin
        t_xchg want;
        s_hs <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                reply_q.push_back(cur_beat);
                in_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_count++;
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got tx_byte %02h end %0b",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_axis_tdata !== want.tx) begin
                        $display("%0t: tx_byte (rx %02h) expected %02h, got %02h",
                                 $time, want.rx, want.tx, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.sess_end) begin
                        $display("%0t: session_end (rx %02h) expected %0b, got %0b",
                                 $time, want.rx, want.sess_end, m_axis_tuser[0]);
                        errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        bit timed_out;
        timed_out = 1'b0;

        // directed: noise, failed T, unknown command, both session ends
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(lmtm_pkg::CH_G_UP);
        put_byte(lmtm_pkg::CH_G_LO);
        put_byte(lmtm_pkg::CH_G_UP);
        put_byte(lmtm_pkg::CH_T_UP);
        put_byte(CMD_CODES);
        put_byte(lmtm_pkg::CH_G_UP);
        put_byte(lmtm_pkg::CH_T_UP);
        put_byte(lmtm_pkg::CMD_END);
        put_byte(lmtm_pkg::CH_G_UP);
        put_byte(lmtm_pkg::CH_T_UP);
        put_byte(lmtm_pkg::CMD_END_ACK);
        put_byte(8'hFF);
        // directed: load at a remapped top address, then close with a zero record
        put_byte(lmtm_pkg::CH_G_UP);
        put_byte(lmtm_pkg::CH_T_UP);
        put_byte(lmtm_pkg::CMD_LOAD);
        put_word(32'hFFFF_FFFF);
        put_word(32'd2);
        put_byte(8'hFF);
        put_byte(8'h00);
        load_base.push_back(lmtm_pkg::REMAP_HIGH);
        load_len.push_back(32'd2);
        put_record(32'd0, 32'hFFFF_FFFF);
        put_byte(8'h00);

        while (host_q.size() < ITEM_GOAL)
            gen_session();
        total_items = host_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && (in_count < total_items || reply_q.size() != 0)) begin
            @(negedge i_clk);
            if (quiet_cycles >= STALL_MAX)
                timed_out = 1'b1;
        end
        if (!timed_out)
            repeat (DRAIN_CYC) @(negedge i_clk);

        if (!timed_out && errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
